[design/rtp_header_parser_macros.svh]
// ----------------------------------------------------------------------------
// RTP header parser assertion macros
// Shared concurrent assertion forms for the parser checkers.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_MACROS_SVH
`define RTP_HEADER_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RHP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtp header parser: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtp header parser: next-cycle check failed");

`endif

[design/rhp_pkg.sv]
// ----------------------------------------------------------------------------
// RTP header parser package
// Types, status codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package rhp_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 65535;
	localparam int IDX_W   = 17;   // byte index, holds up to 65536
	localparam int SPAN_W  = 19;   // header span incl. extension body
	localparam int FIXED_HDR_BYTES = 12;
	localparam logic [1:0] RTP_VERSION = 2'd2;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_VERSION   = 4'd2,
		ST_CSRC      = 4'd3,
		ST_EXT_HDR   = 4'd4,
		ST_EXT_BODY  = 4'd5,
		ST_EMPTY_PAD = 4'd6,
		ST_PAD_COUNT = 4'd7,
		ST_OVERFLOW  = 4'd8
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} pkt_beat_t;

	typedef struct packed {
		status_t     status;
		logic        padding_flag;
		logic        extension_flag;
		logic [3:0]  csrc_count;
		logic        marker_bit;
		logic [6:0]  payload_type;
		logic [15:0] sequence_number;
		logic [31:0] timestamp;
		logic [31:0] source_id;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} result_t;

	// header snapshot taken on the final byte of a packet
	typedef struct packed {
		logic [7:0]       first_byte;
		logic [7:0]       second_byte;
		logic [15:0]      seq;
		logic [31:0]      ts;
		logic [31:0]      ssrc;
		logic [15:0]      ext_words;
		logic [IDX_W-1:0] last_idx;
		logic [7:0]       last_byte;
	} snapshot_t;

endpackage

[design/rhp_stream_if.sv]
// ----------------------------------------------------------------------------
// RTP header parser stream interface
// Valid/ready channel carrying one beat of a typed payload.
// ----------------------------------------------------------------------------
interface rhp_stream_if #(
	parameter type payload_t = rhp_pkg::pkt_beat_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[design/rhp_capture.sv]
// ----------------------------------------------------------------------------
// RTP header capture stage
// Byte counter and header field capture; snapshots the header on the
// final byte into the stage-1 register and clears for the next packet.
// ----------------------------------------------------------------------------
module rhp_capture #(
	parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat_valid,
	output logic                beat_ready,
	input  rhp_pkg::pkt_beat_t  beat,
	output logic                snap_valid,
	input  logic                snap_take,
	output rhp_pkg::snapshot_t  snap
);

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
	localparam logic [rhp_pkg::IDX_W-1:0] CNT_SAT = rhp_pkg::IDX_W'(MAX_PACKET_BYTES + 1);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       fhb_q, shb_q;
	logic [15:0]      seq_q, ewc_q;
	logic [31:0]      time_q, src_q;

	logic [7:0]       fhb_n, shb_n;
	logic [15:0]      seq_n, ewc_n;
	logic [31:0]      time_n, src_n;
	logic [rhp_pkg::IDX_W-1:0] idx;
	logic [rhp_pkg::IDX_W-1:0] hl;
	logic             accept;
	logic             snap_valid_s1;
	rhp_pkg::snapshot_t snap_s1;

	assign idx        = rhp_pkg::IDX_W'(count_q);
	assign beat_ready = !snap_valid_s1 || snap_take;
	assign accept     = beat_valid && beat_ready;

	always_comb begin
		fhb_n  = (idx == 17'd0) ? beat.data_byte : fhb_q;
		shb_n  = (idx == 17'd1) ? beat.data_byte : shb_q;
		seq_n  = seq_q;
		time_n = time_q;
		src_n  = src_q;
		if (idx >= 17'd2 && idx < 17'd4) begin
			seq_n = {seq_q[7:0], beat.data_byte};
		end else if (idx >= 17'd4 && idx < 17'd8) begin
			time_n = {time_q[23:0], beat.data_byte};
		end else if (idx >= 17'd8 && idx < 17'd12) begin
			src_n = {src_q[23:0], beat.data_byte};
		end
		hl    = 17'd12 + {11'd0, fhb_n[3:0], 2'b00};
		ewc_n = ewc_q;
		if (idx == hl + 17'd2) begin
			ewc_n = {beat.data_byte, ewc_q[7:0]};
		end else if (idx == hl + 17'd3) begin
			ewc_n = {ewc_q[15:8], beat.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fhb_q   <= '0;
			shb_q   <= '0;
			seq_q   <= '0;
			time_q  <= '0;
			src_q   <= '0;
			ewc_q   <= '0;
		end else if (accept) begin
			if (beat.end_of_packet) begin
				count_q <= '0;
				fhb_q   <= '0;
				shb_q   <= '0;
				seq_q   <= '0;
				time_q  <= '0;
				src_q   <= '0;
				ewc_q   <= '0;
			end else begin
				if (idx < CNT_SAT) begin
					count_q <= count_q + CNT_W'(1);
				end
				fhb_q  <= fhb_n;
				shb_q  <= shb_n;
				seq_q  <= seq_n;
				time_q <= time_n;
				src_q  <= src_n;
				ewc_q  <= ewc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && beat.end_of_packet) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_take) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && beat.end_of_packet) begin
			snap_s1.first_byte  <= fhb_n;
			snap_s1.second_byte <= shb_n;
			snap_s1.seq         <= seq_n;
			snap_s1.ts          <= time_n;
			snap_s1.ssrc        <= src_n;
			snap_s1.ext_words   <= ewc_n;
			snap_s1.last_idx    <= idx;
			snap_s1.last_byte   <= beat.data_byte;
		end
	end

	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

endmodule

[design/rhp_check.sv]
// ----------------------------------------------------------------------------
// RTP header check stage
// Status evaluation, payload offset and length, and the result register.
// ----------------------------------------------------------------------------
module rhp_check #(
	parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               snap_valid,
	output logic               snap_take,
	input  rhp_pkg::snapshot_t snap,
	output logic               res_valid,
	input  logic               res_ready,
	output rhp_pkg::result_t   res
);

	localparam int SW = rhp_pkg::SPAN_W;

	logic [rhp_pkg::IDX_W-1:0] len;
	logic [SW-1:0]   len_w, hl, ext_end, hl_tot, plen, plen_fin, pad;
	logic            p_bit, x_bit, overflow, too_short;
	rhp_pkg::status_t status;
	rhp_pkg::result_t nxt;
	logic            res_valid_s2;
	rhp_pkg::result_t res_s2;

	always_comb begin
		len       = snap.last_idx + 17'd1;
		len_w     = SW'(len);
		p_bit     = snap.first_byte[5];
		x_bit     = snap.first_byte[4];
		pad       = SW'(snap.last_byte);
		overflow  = snap.last_idx >= rhp_pkg::IDX_W'(MAX_PACKET_BYTES);
		too_short = snap.last_idx < 17'(rhp_pkg::FIXED_HDR_BYTES - 1);
		hl        = SW'(rhp_pkg::FIXED_HDR_BYTES) + SW'({snap.first_byte[3:0], 2'b00});
		ext_end   = hl + SW'(4) + SW'({snap.ext_words, 2'b00});
		hl_tot    = x_bit ? ext_end : hl;
		plen      = len_w - hl_tot;
		plen_fin  = p_bit ? plen - pad : plen;

		if (overflow) begin
			status = rhp_pkg::ST_OVERFLOW;
		end else if (too_short) begin
			status = rhp_pkg::ST_SHORT;
		end else if (snap.first_byte[7:6] != rhp_pkg::RTP_VERSION) begin
			status = rhp_pkg::ST_VERSION;
		end else if (len_w < hl) begin
			status = rhp_pkg::ST_CSRC;
		end else if (x_bit && len_w < hl + SW'(4)) begin
			status = rhp_pkg::ST_EXT_HDR;
		end else if (x_bit && len_w < ext_end) begin
			status = rhp_pkg::ST_EXT_BODY;
		end else if (p_bit && plen == '0) begin
			status = rhp_pkg::ST_EMPTY_PAD;
		end else if (p_bit && (pad == '0 || pad > plen)) begin
			status = rhp_pkg::ST_PAD_COUNT;
		end else begin
			status = rhp_pkg::ST_OK;
		end

		nxt = '0;
		nxt.status = status;
		if (status != rhp_pkg::ST_SHORT) begin
			nxt.padding_flag    = p_bit;
			nxt.extension_flag  = x_bit;
			nxt.csrc_count      = snap.first_byte[3:0];
			nxt.marker_bit      = snap.second_byte[7];
			nxt.payload_type    = snap.second_byte[6:0];
			nxt.sequence_number = snap.seq;
			nxt.timestamp       = snap.ts;
			nxt.source_id       = snap.ssrc;
		end
		if (status == rhp_pkg::ST_OK) begin
			nxt.payload_offset = hl_tot[15:0];
			nxt.payload_length = plen_fin[15:0];
		end
	end

	assign snap_take = snap_valid && (!res_valid_s2 || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (snap_take) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take) begin
			res_s2 <= nxt;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

[design/rtp_header_parser.sv]
// A result passes through the stage-1 header snapshot and then the result register.
// Throughput: one byte per cycle while no snapshot waits on a held result;
// one header result per packet. These two registers set the latency.
// Reset clears the byte counter, captured header fields and both valid flags.
// ----------------------------------------------------------------------------
// RTP header parser
// Parses the RTP fixed header byte by byte and reports status and layout.
// ----------------------------------------------------------------------------
module rtp_header_parser #(
	parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rhp_stream_if.sink    pkt,
	rhp_stream_if.source  res
);

	logic               snap_valid;
	logic               snap_take;
	rhp_pkg::snapshot_t snap;
	rhp_pkg::pkt_beat_t beat;
	rhp_pkg::result_t   result;

	assign beat.data_byte     = pkt.payload.data_byte;
	assign beat.end_of_packet = pkt.payload.end_of_packet;

	rhp_capture #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (pkt.valid),
		.beat_ready (pkt.ready),
		.beat       (beat),
		.snap_valid (snap_valid),
		.snap_take  (snap_take),
		.snap       (snap)
	);

	rhp_check #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_take  (snap_take),
		.snap       (snap),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.res        (result)
	);

	assign res.payload = result;

endmodule

[design/rhp_checker.sv]
// ----------------------------------------------------------------------------
// RTP header parser checker
// Port-level assertions on result beats, bound to the parser top level.
// ----------------------------------------------------------------------------
`include "rtp_header_parser_macros.svh"

module rhp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input rhp_pkg::result_t res
);

	`RHP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res))
	`RHP_ASSERT_SAME(a_err_no_layout, clk, arst_n, res_valid && res.status != rhp_pkg::ST_OK, res.payload_offset == 16'd0 && res.payload_length == 16'd0)
	`RHP_ASSERT_SAME(a_short_zero, clk, arst_n, res_valid && res.status == rhp_pkg::ST_SHORT, res.csrc_count == 4'd0 && res.payload_type == 7'd0 && res.sequence_number == 16'd0 && res.timestamp == 32'd0 && res.source_id == 32'd0)
	`RHP_ASSERT_SAME(a_ok_offset, clk, arst_n, res_valid && res.status == rhp_pkg::ST_OK, res.payload_offset >= 16'd12 && res.payload_offset[1:0] == 2'b00)

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res       (res.payload)
);
